[rtl/core/pwss_pkg.sv]
`default_nettype none

package pwss_pkg;

  // coordinate width on the pixel channel, two's complement
  localparam int COORD_BITS = 12;
  // magnitude bits of a non-negative coordinate
  localparam int POS_BITS   = COORD_BITS - 1;
  // panel size registers
  localparam int PANEL_BITS = 11;
  localparam int OPCODE_BITS = 8;
  // widest configuration register
  localparam int CFG_DATA_BITS = PANEL_BITS;
  localparam int CFG_INDEX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_OPCODE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGE_OPCODE   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MEMWR_OPCODE  = 3'd4;

  // reset values of the configuration registers
  localparam logic [PANEL_BITS-1:0]  PANEL_WIDTH_RESET   = 11'd320;
  localparam logic [PANEL_BITS-1:0]  PANEL_HEIGHT_RESET  = 11'd480;
  localparam logic [OPCODE_BITS-1:0] COLUMN_OPCODE_RESET = 8'h2A;
  localparam logic [OPCODE_BITS-1:0] PAGE_OPCODE_RESET   = 8'h2B;
  localparam logic [OPCODE_BITS-1:0] MEMWR_OPCODE_RESET  = 8'h2C;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [15:0]                  pixel_color;
  } pixel_t;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_command;
    logic       last_byte;
  } link_t;

endpackage

`default_nettype wire

[rtl/core/pixel_window_spi_serializer_core.sv]
`default_nettype none

// channel   direction  handshake                  payload
// pixel     in         pixel_valid / pixel_stall  pixel (x, y, rgb565 color)
// link      out        link_valid / link_stall    link (byte, command flag, last flag)
// config    in         cfg_we                     cfg_index, cfg_data
//
// an in-window pixel gives 13 link beats, one per cycle while link_stall does not hold the link register;
// the rate is set by the single byte select behind the pixel hold register
// an out-of-window pixel is taken and dropped and gives no beat
// the next pixel is taken in the cycle the 13th byte moves to the link register
// rst is synchronous, active high; config returns to 320 x 480 and opcodes 2a/2b/2c
// link_stall holds the link register and, once the hold register is full, the pixel side

module pixel_window_spi_serializer_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  pixel_valid,
  output logic                                       pixel_stall,
  input  wire pwss_pkg::pixel_t                      pixel,
  output logic                                       link_valid,
  input  wire logic                                  link_stall,
  output pwss_pkg::link_t                            link,
  input  wire logic                                  cfg_we,
  input  wire logic [pwss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [pwss_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import pwss_pkg::*;

  // position of the byte being sent within one pixel write
  typedef enum logic [3:0] {
    POS_CASET,
    POS_XS_HI,
    POS_XS_LO,
    POS_XE_HI,
    POS_XE_LO,
    POS_PASET,
    POS_YS_HI,
    POS_YS_LO,
    POS_YE_HI,
    POS_YE_LO,
    POS_RAMWR,
    POS_COLOR_HI,
    POS_COLOR_LO
  } byte_pos_t;

  // configuration registers
  logic [PANEL_BITS-1:0]  panel_width;
  logic [PANEL_BITS-1:0]  panel_height;
  logic [OPCODE_BITS-1:0] column_opcode;
  logic [OPCODE_BITS-1:0] page_opcode;
  logic [OPCODE_BITS-1:0] memwr_opcode;

  // pixel hold register
  logic                hold_valid;
  byte_pos_t           byte_pos;
  logic [POS_BITS-1:0] hold_x;
  logic [POS_BITS-1:0] hold_y;
  logic [15:0]         hold_color;

  logic      pixel_accept;
  logic      in_window;
  logic      link_load;
  logic      advance;
  logic      hold_done;
  logic [15:0] x_word;
  logic [15:0] y_word;
  link_t     link_next;

  // window check: sign bit clear and magnitude below the panel size
  assign in_window = !pixel.pixel_x[COORD_BITS-1] && !pixel.pixel_y[COORD_BITS-1]
                   && (pixel.pixel_x[POS_BITS-1:0] < panel_width)
                   && (pixel.pixel_y[POS_BITS-1:0] < panel_height);

  // link register takes a new byte when empty or when its beat completes
  assign link_load = !link_valid || !link_stall;
  assign advance   = hold_valid && link_load;
  assign hold_done = advance && (byte_pos == POS_COLOR_LO);

  // full hold register frees up in the cycle its last byte moves out
  assign pixel_stall  = hold_valid && !hold_done;
  assign pixel_accept = pixel_valid && !pixel_stall;

  assign x_word = 16'(hold_x);
  assign y_word = 16'(hold_y);

  // byte select for the current position
  always_comb begin
    link_next.link_byte  = 8'h00;
    link_next.is_command = 1'b0;
    link_next.last_byte  = 1'b0;
    case (byte_pos)
      POS_CASET: begin
        link_next.link_byte  = column_opcode;
        link_next.is_command = 1'b1;
      end
      POS_XS_HI, POS_XE_HI: link_next.link_byte = x_word[15:8];
      POS_XS_LO, POS_XE_LO: link_next.link_byte = x_word[7:0];
      POS_PASET: begin
        link_next.link_byte  = page_opcode;
        link_next.is_command = 1'b1;
      end
      POS_YS_HI, POS_YE_HI: link_next.link_byte = y_word[15:8];
      POS_YS_LO, POS_YE_LO: link_next.link_byte = y_word[7:0];
      POS_RAMWR: begin
        link_next.link_byte  = memwr_opcode;
        link_next.is_command = 1'b1;
      end
      POS_COLOR_HI: link_next.link_byte = hold_color[15:8];
      POS_COLOR_LO: begin
        link_next.link_byte = hold_color[7:0];
        link_next.last_byte = 1'b1;
      end
      default: begin
        link_next.link_byte = 8'h00;
      end
    endcase
  end

  // configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width   <= PANEL_WIDTH_RESET;
      panel_height  <= PANEL_HEIGHT_RESET;
      column_opcode <= COLUMN_OPCODE_RESET;
      page_opcode   <= PAGE_OPCODE_RESET;
      memwr_opcode  <= MEMWR_OPCODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:   panel_width   <= cfg_data;
        CFG_PANEL_HEIGHT:  panel_height  <= cfg_data;
        CFG_COLUMN_OPCODE: column_opcode <= cfg_data[OPCODE_BITS-1:0];
        CFG_PAGE_OPCODE:   page_opcode   <= cfg_data[OPCODE_BITS-1:0];
        CFG_MEMWR_OPCODE:  memwr_opcode  <= cfg_data[OPCODE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // hold register control; out-of-window pixels are taken and dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      byte_pos   <= POS_CASET;
    end else if (pixel_accept) begin
      hold_valid <= in_window;
      byte_pos   <= POS_CASET;
    end else if (advance) begin
      hold_valid <= !hold_done;
      byte_pos   <= byte_pos_t'(byte_pos + 4'd1);
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      hold_x     <= pixel.pixel_x[POS_BITS-1:0];
      hold_y     <= pixel.pixel_y[POS_BITS-1:0];
      hold_color <= pixel.pixel_color;
    end
  end

  // link output register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= 1'b0;
    end else if (link_load) begin
      link_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      link <= link_next;
    end
  end

`ifndef SYNTHESIS
  // an in-window pixel always starts a fresh byte sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    pixel_accept && in_window |=> hold_valid && (byte_pos == POS_CASET))
    else $error("in-window pixel did not start at the column command");

  // the last flag marks exactly the color low byte
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    advance |=> link_valid && (link.last_byte == $past(byte_pos == POS_COLOR_LO)))
    else $error("last flag out of place");

  // the pixel side waits only while a pixel is still being sent
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> hold_valid && !hold_done)
    else $error("pixel side stalled with nothing to send");

  // after the final byte leaves, the hold register is free unless refilled
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    hold_done && !(pixel_valid && in_window) |=> !hold_valid)
    else $error("hold register still busy after its last byte");
`endif

endmodule

`default_nettype wire
